[hw/rtl/vptd_pkg.sv]
package vptd_pkg;

    localparam int PROCESS_COUNT = 8;
    localparam int IDX_W = (PROCESS_COUNT > 1) ? $clog2(PROCESS_COUNT) : 1;
    localparam int MAX_OUT = 8;
    localparam int OUT_CNT_W = $clog2(MAX_OUT + 1);

    localparam int COUNT_W = 10;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;
    localparam logic [11:0] RATE_MIN_HZ = 12'd2;
    localparam logic [11:0] RATE_MAX_HZ = 12'd1024;
    localparam logic [3:0] PHYS_EXP_RESET = 4'd1;
    localparam logic [4:0] SELECT_BASE = 5'd16;

    typedef enum logic [2:0] {
        ACT_TICK  = 3'd0,
        ACT_OPEN  = 3'd1,
        ACT_WRITE = 3'd2,
        ACT_READ  = 3'd3,
        ACT_CLOSE = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        KIND_ACCEPT = 2'd0,
        KIND_REJECT = 2'd1,
        KIND_DONE   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    // broadcast to every cell; request fields only act where sel is high
    typedef struct packed {
        logic       tick;
        logic       open;
        logic       write;
        logic       read;
        logic       close;
        logic [3:0] rate;
        logic [3:0] shift;
    } vptd_cmd_t;

    function automatic logic [3:0] log2_of(input logic [11:0] f);
        logic [3:0] e;
        e = 4'd0;
        for (int i = 1; i < 12; i++) begin
            if (f[i]) begin
                e = 4'(i);
            end
        end
        return e;
    endfunction

    function automatic logic [3:0] rate_select_of(input logic [3:0] phys);
        return 4'(SELECT_BASE - {1'b0, phys});
    endfunction

endpackage

[hw/rtl/vptd_cell.sv]
module vptd_cell
    import vptd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  vptd_cmd_t  cmd,
    input  logic       sel,
    input  logic       token_in,
    input  logic       stall,
    input  logic       abort,
    output logic       token_out,
    output logic       hit,
    output logic [3:0] rate_exp
);

    logic [3:0]         rate_reg, rate_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [3:0]         shift_reg, shift_next;
    logic               wait_reg, wait_next;
    logic               token_reg, token_next;
    logic               done;

    assign done = wait_reg && (16'(count_reg) >= (16'd1 << shift_reg));
    assign hit = token_reg && done;
    assign token_out = token_reg;
    assign rate_exp = rate_reg;

    always_comb begin
        rate_next = rate_reg;
        count_next = count_reg;
        shift_next = shift_reg;
        wait_next = wait_reg;
        token_next = token_reg;

        if (cmd.tick && count_reg < COUNT_MAX) begin
            count_next = count_reg + 1'b1;
        end
        if (sel) begin
            if (cmd.open) begin
                rate_next = 4'd1;
            end
            if (cmd.write) begin
                rate_next = cmd.rate;
            end
            if (cmd.read) begin
                count_next = '0;
                shift_next = cmd.shift;
                wait_next = 1'b1;
            end
            if (cmd.close) begin
                rate_next = 4'd0;
                wait_next = 1'b0;
            end
        end
        // completion handed on: wait is over
        if (hit && !stall) begin
            wait_next = 1'b0;
        end

        if (abort) begin
            token_next = 1'b0;
        end else if (!stall) begin
            token_next = token_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg <= '0;
            count_reg <= '0;
            shift_reg <= '0;
            wait_reg <= 1'b0;
            token_reg <= 1'b0;
        end else begin
            rate_reg <= rate_next;
            count_reg <= count_next;
            shift_reg <= shift_next;
            wait_reg <= wait_next;
            token_reg <= token_next;
        end
    end

endmodule

[hw/rtl/virtual_periodic_tick_divider_top.sv]
// Virtual periodic tick divider: one virtual periodic tick per process, all derived
// from one shared physical tick.
// Input channel s_*: one request per transfer; s_tuser carries the action (tick, open,
// write rate, read wait, close), s_tdata the process and the requested rate.
// Output channel m_*: results with kind in m_tuser; m_tlast marks the final result
// caused by one request.
// A request (open, write, read, close) gives its single result in the cycle after it
// is taken; the block is ready again in the next cycle if the output is free.
// A tick sends a token down the chain of process cells, one cell per cycle while
// no stall holds it; each cell with a finished wait yields a completion, and a tick
// gives no result when no wait finished.
// Completions are held one deep so that the final one can carry m_tlast.
// When m_tready is low one completion waits on the output and one more in the hold
// stage; the token stops only at a further cell with a finished wait. s_tready stays
// low until the tick is done, so nothing is lost. Reset clears every process (no rate,
// no wait, counters zero) and sets the physical rate to 2 Hz; the block accepts
// requests in the first cycle after reset.
module virtual_periodic_tick_divider_top
    import vptd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [2:0] process, [14:3] frequency
    input  logic [2:0]  s_tuser,   // [2:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [2:0] process_res, [6:3] rate_select
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);

    state_t state_reg, state_next;

    logic               m_valid_reg, m_valid_next;
    logic [1:0]         m_kind_reg, m_kind_next;
    logic [2:0]         m_proc_reg, m_proc_next;
    logic [3:0]         m_rsel_reg, m_rsel_next;
    logic               m_last_reg, m_last_next;
    logic [3:0]         phys_reg, phys_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [2:0]         pend_proc_reg, pend_proc_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [OUT_CNT_W-1:0] cnt_reg, cnt_next;

    logic [2:0]  in_action;
    logic [2:0]  in_proc;
    logic [11:0] in_freq;
    logic        out_free, accept, start;
    logic        proc_ok, freq_ok, req_ok;
    logic [3:0]  freq_exp, rate_cur;
    logic        stall, abort, any_hit, last_idx;
    vptd_cmd_t   cmd;

    logic [PROCESS_COUNT-1:0]   sel, hit, tok_out;
    logic [PROCESS_COUNT:0]     tok_chain;
    logic [PROCESS_COUNT-1:0][3:0] rate_exp;

    assign in_action = s_tuser;
    assign in_proc = s_tdata[2:0];
    assign in_freq = s_tdata[14:3];

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept = s_tvalid && s_tready;
    assign start = accept && (in_action == ACT_TICK);

    assign proc_ok = 7'(in_proc) < 7'(PROCESS_COUNT);
    assign freq_exp = log2_of(in_freq);
    assign freq_ok = (in_freq >= RATE_MIN_HZ) && (in_freq <= RATE_MAX_HZ)
                     && ((in_freq & (in_freq - 12'd1)) == 12'd0);

    always_comb begin
        rate_cur = 4'd0;
        for (int i = 0; i < PROCESS_COUNT; i++) begin
            sel[i] = proc_ok && (7'(in_proc) == 7'(i));
            if (sel[i]) begin
                rate_cur = rate_exp[i];
            end
        end
    end

    // request decode
    always_comb begin
        cmd = '0;
        req_ok = 1'b0;
        phys_next = phys_reg;
        cmd.tick = start;
        cmd.rate = freq_exp;
        cmd.shift = phys_reg - rate_cur;
        if (accept && proc_ok) begin
            unique case (in_action)
                ACT_OPEN: begin
                    req_ok = 1'b1;
                    cmd.open = 1'b1;
                end
                ACT_WRITE: begin
                    if (freq_ok) begin
                        req_ok = 1'b1;
                        cmd.write = 1'b1;
                        if (phys_reg < freq_exp) begin
                            phys_next = freq_exp;
                        end
                    end
                end
                ACT_READ: begin
                    if (rate_cur >= 4'd1 && rate_cur <= phys_reg) begin
                        req_ok = 1'b1;
                        cmd.read = 1'b1;
                    end
                end
                ACT_CLOSE: begin
                    req_ok = 1'b1;
                    cmd.close = 1'b1;
                end
                default: begin
                    req_ok = 1'b0;
                end
            endcase
        end
    end

    assign tok_chain[0] = start;

    genvar g;
    generate
        for (g = 0; g < PROCESS_COUNT; g++) begin : g_cell
            vptd_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .cmd       (cmd),
                .sel       (sel[g]),
                .token_in  (tok_chain[g]),
                .stall     (stall),
                .abort     (abort),
                .token_out (tok_out[g]),
                .hit       (hit[g]),
                .rate_exp  (rate_exp[g])
            );
            assign tok_chain[g+1] = tok_out[g];
        end
    endgenerate

    assign any_hit = |hit;
    assign last_idx = idx_reg == IDX_W'(PROCESS_COUNT - 1);
    assign stall = (state_reg == ST_SCAN) && any_hit && pend_valid_reg && !out_free;

    always_comb begin
        state_next = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_kind_next = m_kind_reg;
        m_proc_next = m_proc_reg;
        m_rsel_next = m_rsel_reg;
        m_last_next = m_last_reg;
        pend_valid_next = pend_valid_reg;
        pend_proc_next = pend_proc_reg;
        idx_next = idx_reg;
        cnt_next = cnt_reg;
        abort = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (in_action == ACT_TICK) begin
                        state_next = ST_SCAN;
                        idx_next = '0;
                        cnt_next = '0;
                    end else begin
                        m_valid_next = 1'b1;
                        m_kind_next = req_ok ? KIND_ACCEPT : KIND_REJECT;
                        m_proc_next = in_proc;
                        m_rsel_next = rate_select_of(phys_next);
                        m_last_next = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (!stall) begin
                    if (any_hit) begin
                        // previous completion leaves, this one is held back
                        if (pend_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_kind_next = KIND_DONE;
                            m_proc_next = pend_proc_reg;
                            m_rsel_next = rate_select_of(phys_reg);
                            m_last_next = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_proc_next = 3'(idx_reg);
                        cnt_next = cnt_reg + 1'b1;
                    end
                    idx_next = idx_reg + 1'b1;
                    if (last_idx || (any_hit && cnt_next == OUT_CNT_W'(MAX_OUT))) begin
                        abort = 1'b1;
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next = KIND_DONE;
                    m_proc_next = pend_proc_reg;
                    m_rsel_next = rate_select_of(phys_reg);
                    m_last_next = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            phys_reg <= PHYS_EXP_RESET;
            idx_reg <= '0;
            cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
            pend_valid_reg <= pend_valid_next;
            phys_reg <= phys_next;
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_kind_reg <= m_kind_next;
        m_proc_reg <= m_proc_next;
        m_rsel_reg <= m_rsel_next;
        m_last_reg <= m_last_next;
        pend_proc_reg <= pend_proc_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = {1'b0, m_rsel_reg, m_proc_reg};
    assign m_tuser = m_kind_reg;
    assign m_tlast = m_last_reg;

endmodule

[hw/rtl/vptd_checker.sv]
module vptd_checker
    import vptd_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // a result held back by the receiver stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a request other than a tick answers in the next cycle with a single result
    a_req_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser != ACT_TICK |=> m_tvalid && m_tlast
        && (m_tuser == KIND_ACCEPT || m_tuser == KIND_REJECT))
        else $error("request result missing");

    // physical rate selector stays between 1024 Hz and 2 Hz, and kind is accept, reject or done
    a_rsel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[6:3] >= 4'd6 && m_tuser <= KIND_DONE)
        else $error("result fields out of range");

    // no new request while a completion run is still open
    a_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser == KIND_DONE && !m_tlast |-> !s_tready)
        else $error("request taken inside a completion run");

endmodule

bind virtual_periodic_tick_divider_top vptd_checker u_vptd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import vptd_pkg::*;

    // actions past close are not defined; the block must reject them
    localparam logic [2:0] ACT_UNKNOWN_LO = 3'd5;
    localparam logic [2:0] ACT_UNKNOWN_HI = 3'd7;
    localparam int RANDOM_ITEMS = 400;
    localparam int CALM_ITEMS = 60;
    localparam int HOLD_AT = 150;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [1:0] kind;
        logic [2:0] proc;
        logic [3:0] sel;
        logic       last;
    } outcome_t;

    class tick_scoreboard;
        logic [3:0]  rate_exp [PROCESS_COUNT];
        logic [9:0]  ticks [PROCESS_COUNT];
        logic [3:0]  shift_len [PROCESS_COUNT];
        bit          armed [PROCESS_COUNT];
        logic [3:0]  phys_exp;
        outcome_t    due [$];
        int          errors;

        function new();
            foreach (rate_exp[p]) begin
                rate_exp[p] = 4'd0;
                ticks[p] = '0;
                shift_len[p] = 4'd0;
                armed[p] = 1'b0;
            end
            phys_exp = PHYS_EXP_RESET;
            errors = 0;
        endfunction

        function logic [3:0] select_now();
            return 4'(SELECT_BASE - {1'b0, phys_exp});
        endfunction

        // work out the results of one accepted request and queue them
        function void note(logic [2:0] act, logic [2:0] proc, logic [11:0] freq);
            bit ok;
            int e;
            int finished [$];
            outcome_t o;
            ok = 1'b0;
            if (act == ACT_TICK) begin
                foreach (ticks[p]) begin
                    if (ticks[p] < COUNT_MAX) ticks[p]++;
                end
                for (int p = 0; p < PROCESS_COUNT && finished.size() < MAX_OUT; p++) begin
                    if (armed[p] && int'(ticks[p]) >= (1 << shift_len[p])) begin
                        armed[p] = 1'b0;
                        finished.push_back(p);
                    end
                end
                foreach (finished[k]) begin
                    o = '{KIND_DONE, 3'(finished[k]), select_now(),
                          k == finished.size() - 1};
                    due.push_back(o);
                end
                return;
            end
            if (int'(proc) < PROCESS_COUNT) begin
                case (act)
                    ACT_OPEN: begin
                        rate_exp[proc] = 4'd1;
                        ok = 1'b1;
                    end
                    ACT_WRITE: begin
                        if (freq >= RATE_MIN_HZ && freq <= RATE_MAX_HZ &&
                            (freq & (freq - 12'd1)) == 12'd0) begin
                            e = $clog2(freq);
                            rate_exp[proc] = 4'(e);
                            if (phys_exp < 4'(e)) phys_exp = 4'(e);
                            ok = 1'b1;
                        end
                    end
                    ACT_READ: begin
                        if (rate_exp[proc] >= 4'd1 && rate_exp[proc] <= phys_exp) begin
                            ticks[proc] = '0;
                            shift_len[proc] = phys_exp - rate_exp[proc];
                            armed[proc] = 1'b1;
                            ok = 1'b1;
                        end
                    end
                    ACT_CLOSE: begin
                        rate_exp[proc] = 4'd0;
                        armed[proc] = 1'b0;
                        ok = 1'b1;
                    end
                    default: ok = 1'b0;
                endcase
            end
            o = '{ok ? KIND_ACCEPT : KIND_REJECT, proc, select_now(), 1'b1};
            due.push_back(o);
        endfunction

        task report(string msg);
            $display("%0t mismatch: %s", $time, msg);
            errors++;
        endtask

        task check(logic [1:0] kind, logic [2:0] proc, logic [3:0] sel, logic last);
            outcome_t want;
            if (due.size() == 0) begin
                report($sformatf("unexpected result kind %0d process %0d", kind, proc));
                return;
            end
            want = due.pop_front();
            if (kind !== want.kind)
                report($sformatf("kind %0d, want %0d", kind, want.kind));
            if (proc !== want.proc)
                report($sformatf("process %0d, want %0d", proc, want.proc));
            if (sel !== want.sel)
                report($sformatf("rate select %0d, want %0d", sel, want.sel));
            if (last !== want.last)
                report($sformatf("last %0b, want %0b", last, want.last));
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [2:0] process, [14:3] frequency
    logic [2:0]  s_tuser;   // [2:0] action
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [2:0] process_res, [6:3] rate_select
    logic [1:0]  m_tuser;   // [1:0] kind
    logic        m_tlast;

    tick_scoreboard board;
    bit calm;
    int hold_left;

    virtual_periodic_tick_divider_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_request(input logic [2:0] act, input logic [2:0] proc,
                                input logic [11:0] freq);
        int gap;
        @(negedge aclk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {1'b0, freq, proc};
        do @(posedge aclk); while (!s_tready);
        board.note(act, proc, freq);
    endtask

    // result side: random stall bursts, plus one long hold-off to back up the block
    initial begin : sink
        int gap;
        gap = 0;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (gap > 0) begin
                m_tready <= 1'b0;
                gap--;
            end else begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 6) == 0) gap = $urandom_range(1, 11);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check(m_tuser, m_tdata[2:0], m_tdata[6:3], m_tlast);
    end

    initial begin
        int r;
        int lo;
        int hi;
        int p;
        int good [$];
        logic [2:0] act;
        logic [11:0] freq;

        board = new();
        calm = 1'b0;
        hold_left = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = ACT_TICK;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: bad rates, read without rate, re-arm, close while waiting
        send_request(ACT_OPEN, 3'd0, 12'd0);
        send_request(ACT_READ, 3'd0, 12'd0);
        send_request(ACT_TICK, 3'd5, 12'hFFF);
        send_request(ACT_WRITE, 3'd0, 12'd0);
        send_request(ACT_WRITE, 3'd0, 12'd1);
        send_request(ACT_WRITE, 3'd0, 12'd3);
        send_request(ACT_WRITE, 3'd0, 12'hFFF);
        send_request(ACT_WRITE, 3'd0, 12'd2048);
        send_request(ACT_WRITE, 3'd7, 12'd1025);
        send_request(ACT_READ, 3'd7, 12'd0);
        send_request(ACT_UNKNOWN_LO, 3'd7, 12'hFFF);
        send_request(ACT_UNKNOWN_HI, 3'd2, 12'd4);
        send_request(ACT_WRITE, 3'd1, 12'd2);
        send_request(ACT_WRITE, 3'd2, 12'd4);
        send_request(ACT_READ, 3'd2, 12'd0);
        send_request(ACT_READ, 3'd1, 12'd0);
        send_request(ACT_TICK, 3'd0, 12'd0);
        send_request(ACT_READ, 3'd1, 12'd0);
        send_request(ACT_OPEN, 3'd3, 12'd0);
        send_request(ACT_READ, 3'd3, 12'd0);
        send_request(ACT_CLOSE, 3'd3, 12'd0);
        send_request(ACT_TICK, 3'd0, 12'd0);
        send_request(ACT_TICK, 3'd0, 12'd0);
        send_request(ACT_TICK, 3'd0, 12'd0);
        send_request(ACT_CLOSE, 3'd7, 12'd0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == HOLD_AT) hold_left = HOLD_CYCLES;
            calm = (i >= RANDOM_ITEMS - CALM_ITEMS);
            r = $urandom_range(0, 99);
            p = $urandom_range(0, PROCESS_COUNT - 1);
            freq = '0;
            if (r < 35) begin
                act = ACT_TICK;
            end else if (r < 52) begin
                act = ACT_READ;
                // mostly readers whose wait is short at the current physical rate
                good.delete();
                for (int q = 0; q < PROCESS_COUNT; q++) begin
                    if (board.rate_exp[q] != 0 && board.phys_exp - board.rate_exp[q] <= 3)
                        good.push_back(q);
                end
                if (good.size() > 0 && $urandom_range(0, 4) != 0)
                    p = good[$urandom_range(0, good.size() - 1)];
            end else if (r < 72) begin
                act = ACT_WRITE;
                if ($urandom_range(0, 4) == 0) begin
                    freq = 12'($urandom_range(0, 4095));
                end else begin
                    lo = (board.phys_exp > 3) ? board.phys_exp - 2 : 1;
                    hi = (board.phys_exp < 10) ? board.phys_exp + 1 : 10;
                    freq = 12'(1 << $urandom_range(lo, hi));
                end
            end else if (r < 82) begin
                act = ACT_OPEN;
            end else if (r < 89) begin
                act = ACT_CLOSE;
            end else if (r < 93) begin
                act = 3'($urandom_range(ACT_UNKNOWN_LO, ACT_UNKNOWN_HI));
                freq = 12'($urandom_range(0, 4095));
            end else begin
                act = ACT_READ;
            end
            send_request(act, 3'(p), freq);
        end

        // top rate at the end, then a short wait on it
        send_request(ACT_WRITE, 3'd6, RATE_MAX_HZ);
        send_request(ACT_READ, 3'd6, 12'd0);
        send_request(ACT_TICK, 3'd0, 12'd0);
        @(negedge aclk);
        s_tvalid <= 1'b0;

        for (int k = 0; k < 20000 && board.due.size() != 0; k++) @(posedge aclk);
        if (board.due.size() != 0)
            board.report($sformatf("%0d results never arrived", board.due.size()));
        repeat (40) @(posedge aclk);
        if (board.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/vptd_pkg.sv
hw/rtl/vptd_cell.sv
hw/rtl/virtual_periodic_tick_divider_top.sv
hw/rtl/vptd_checker.sv
tb/testbench.sv
